// File: design/bfsncd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsncd_pkg: shared types for the nearest content distance unit
// Operation codes of the input item, field widths and the control states.
// ----------------------------------------------------------------------------
package bfsncd_pkg;

  localparam int OP_W   = 2;
  localparam int VTX_W  = 6;
  localparam int CID_W  = 6;
  localparam int DIST_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE  = 2'd0,
    OP_TAG   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_MODIFY = 6'b000100,
    S_START  = 6'b001000,
    S_EXPAND = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

endpackage

// File: design/bfs_nearest_content_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_nearest_content_distance_unit: hop distance to the nearest tagged vertex
// Holds a directed graph and per-vertex content tags and answers breadth-first
// distance queries with one shared adjacency row reader.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries op_i, vertex_i,
//   dest_vertex_i and content_id_i. Op 0 adds the edge vertex -> dest_vertex,
//   op 1 tags vertex with content_id, op 2 asks for the distance from vertex
//   to the nearest vertex holding content_id; op 3 is dropped. Only queries
//   produce a transfer on the output channel (out_valid_o / out_stall_i,
//   distance_o). in_stall_o is high whenever an item is in progress.
//   Edge and tag items take a row read and a row write-back.
//   A query that needs no search goes through the load, start and done
//   states; a search reads one adjacency row per vertex expanded and spends
//   a further step closing each breadth-first level; the single read port of
//   the adjacency memory, delivering one row per cycle, sets the search pace.
//   The result then sits in an output register, and the next item can be
//   taken in the same cycle as the result appears.
//   If that register still holds an untaken result, a finished query waits
//   until the receiver takes it, and the input stays stalled during the wait.
//   Reset clears the per-row valid bits of both memories, so the graph and
//   the tags start empty at once, with no clearing pass.
// ----------------------------------------------------------------------------
module bfs_nearest_content_distance_unit #(
  parameter int VERTICES = 64,
  parameter int CONTENTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bfsncd_pkg::OP_W-1:0]      op_i,
  input  logic [bfsncd_pkg::VTX_W-1:0]     vertex_i,
  input  logic [bfsncd_pkg::VTX_W-1:0]     dest_vertex_i,
  input  logic [bfsncd_pkg::CID_W-1:0]     content_id_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bfsncd_pkg::DIST_W-1:0]    distance_o
);

  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int CW = (CONTENTS > 1) ? $clog2(CONTENTS) : 1;
  localparam int DW = bfsncd_pkg::DIST_W;

  // Adjacency rows are indexed by source vertex; tag rows are indexed by
  // content and hold one bit per vertex, so a query needs a single read.
  logic [VERTICES-1:0] adj_mem [VERTICES];
  logic [VERTICES-1:0] tag_mem [CONTENTS];
  logic [VERTICES-1:0] adj_vld_q;
  logic [CONTENTS-1:0] tag_vld_q;

  logic [VERTICES-1:0] adj_rd_q, tag_rd_q;
  logic                adj_rvld_q, tag_rvld_q;
  logic [VERTICES-1:0] adj_row, tag_row;

  logic                adj_re, adj_we, tag_re, tag_we;
  logic [VW-1:0]       adj_raddr;

  bfsncd_pkg::state_e  state_q, state_d;
  bfsncd_pkg::op_e     op_q, op_d;
  logic [VW-1:0]       vtx_q, vtx_d, dst_q, dst_d;
  logic [CW-1:0]       cid_q, cid_d;
  logic                vin_q, vin_d, din_q, din_d, cin_q, cin_d;

  logic [VERTICES-1:0] visited_q, visited_d;
  logic [VERTICES-1:0] frontier_q, frontier_d;
  logic [VERTICES-1:0] next_q, next_d;
  logic [VERTICES-1:0] holder_q, holder_d;
  logic                pend_q, pend_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic [DW-1:0]       res_q, res_d;

  logic                out_valid_q, out_valid_d;
  logic [DW-1:0]       distance_q, distance_d;

  logic [VERTICES-1:0] vtx_bit, dst_bit, nacc, nnew;
  logic [VW-1:0]       pick;
  logic                in_xfer;

  assign in_stall_o  = (state_q != bfsncd_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;

  assign adj_row = adj_rvld_q ? adj_rd_q : '0;
  assign tag_row = tag_rvld_q ? tag_rd_q : '0;

  always_comb begin
    vtx_bit = '0;
    dst_bit = '0;
    vtx_bit[vtx_q] = 1'b1;
    dst_bit[dst_q] = 1'b1;
  end

  // Lowest set bit of the frontier picks the next row to fetch.
  always_comb begin
    pick = '0;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (frontier_q[i]) begin
        pick = VW'(i);
      end
    end
  end

  // Row collected this cycle joins the level's successor set.
  assign nacc = next_q | (pend_q ? adj_row : '0);
  assign nnew = nacc & ~visited_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    vtx_d       = vtx_q;
    dst_d       = dst_q;
    cid_d       = cid_q;
    vin_d       = vin_q;
    din_d       = din_q;
    cin_d       = cin_q;
    visited_d   = visited_q;
    frontier_d  = frontier_q;
    next_d      = next_q;
    holder_d    = holder_q;
    pend_d      = pend_q;
    depth_d     = depth_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    distance_d  = distance_q;
    adj_re      = 1'b0;
    adj_we      = 1'b0;
    tag_re      = 1'b0;
    tag_we      = 1'b0;
    adj_raddr   = vtx_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bfsncd_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_d  = bfsncd_pkg::op_e'(op_i);
          vtx_d = VW'(vertex_i);
          dst_d = VW'(dest_vertex_i);
          cid_d = CW'(content_id_i);
          vin_d = (32'(vertex_i) < VERTICES);
          din_d = (32'(dest_vertex_i) < VERTICES);
          cin_d = (32'(content_id_i) < CONTENTS);
          if (op_i == bfsncd_pkg::OP_EDGE || op_i == bfsncd_pkg::OP_TAG ||
              op_i == bfsncd_pkg::OP_QUERY) begin
            state_d = bfsncd_pkg::S_LOAD;
          end
        end
      end
      bfsncd_pkg::S_LOAD: begin
        case (op_q)
          bfsncd_pkg::OP_EDGE: begin
            if (vin_q && din_q) begin
              adj_re  = 1'b1;
              state_d = bfsncd_pkg::S_MODIFY;
            end else begin
              state_d = bfsncd_pkg::S_IDLE;
            end
          end
          bfsncd_pkg::OP_TAG: begin
            if (vin_q && cin_q) begin
              tag_re  = 1'b1;
              state_d = bfsncd_pkg::S_MODIFY;
            end else begin
              state_d = bfsncd_pkg::S_IDLE;
            end
          end
          default: begin
            tag_re  = cin_q;
            state_d = bfsncd_pkg::S_START;
          end
        endcase
      end
      bfsncd_pkg::S_MODIFY: begin
        adj_we  = (op_q == bfsncd_pkg::OP_EDGE);
        tag_we  = (op_q == bfsncd_pkg::OP_TAG);
        state_d = bfsncd_pkg::S_IDLE;
      end
      bfsncd_pkg::S_START: begin
        holder_d = tag_row;
        if (!vin_q || !cin_q) begin
          res_d   = '0;
          state_d = bfsncd_pkg::S_DONE;
        end else if (tag_row[vtx_q]) begin
          res_d   = DW'(1);
          state_d = bfsncd_pkg::S_DONE;
        end else begin
          visited_d  = vtx_bit;
          frontier_d = vtx_bit;
          next_d     = '0;
          pend_d     = 1'b0;
          depth_d    = '0;
          state_d    = bfsncd_pkg::S_EXPAND;
        end
      end
      bfsncd_pkg::S_EXPAND: begin
        next_d = nacc;
        if (frontier_q != '0) begin
          adj_re           = 1'b1;
          adj_raddr        = pick;
          frontier_d[pick] = 1'b0;
          pend_d           = 1'b1;
        end else begin
          // The level is complete once the frontier is drained and the last
          // row has been merged in this cycle.
          pend_d = 1'b0;
          next_d = '0;
          if (nnew == '0) begin
            res_d   = '0;
            state_d = bfsncd_pkg::S_DONE;
          end else if ((nnew & holder_q) != '0) begin
            res_d   = DW'(depth_q + DW'(2));
            state_d = bfsncd_pkg::S_DONE;
          end else begin
            visited_d  = visited_q | nnew;
            frontier_d = nnew;
            depth_d    = DW'(depth_q + DW'(1));
          end
        end
      end
      bfsncd_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          distance_d  = res_q;
          state_d     = bfsncd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfsncd_pkg::S_IDLE;
      end
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[vtx_q] <= adj_row | dst_bit;
    end
    if (adj_re) begin
      adj_rd_q   <= adj_mem[adj_raddr];
      adj_rvld_q <= adj_vld_q[adj_raddr];
    end
    if (tag_we) begin
      tag_mem[cid_q] <= tag_row | vtx_bit;
    end
    if (tag_re) begin
      tag_rd_q   <= tag_mem[cid_q];
      tag_rvld_q <= tag_vld_q[cid_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q   <= '0;
      tag_vld_q   <= '0;
      state_q     <= bfsncd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      visited_q   <= '0;
      frontier_q  <= '0;
      next_q      <= '0;
      depth_q     <= '0;
    end else begin
      if (adj_we) begin
        adj_vld_q[vtx_q] <= 1'b1;
      end
      if (tag_we) begin
        tag_vld_q[cid_q] <= 1'b1;
      end
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      visited_q   <= visited_d;
      frontier_q  <= frontier_d;
      next_q      <= next_d;
      depth_q     <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    vtx_q      <= vtx_d;
    dst_q      <= dst_d;
    cid_q      <= cid_d;
    vin_q      <= vin_d;
    din_q      <= din_d;
    cin_q      <= cin_d;
    holder_q   <= holder_d;
    res_q      <= res_d;
    distance_q <= distance_d;
  end

  // The frontier is always a subset of the visited set.
  a_frontier_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frontier_q & ~visited_q) == '0)
    else $error("frontier holds an unvisited vertex");

  // During a search the start vertex stays marked as visited.
  a_start_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfsncd_pkg::S_EXPAND |-> visited_q[vtx_q])
    else $error("start vertex lost from the visited set");

  // Each level adds at least one vertex, so the depth stays below the order.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfsncd_pkg::S_EXPAND |-> 32'(depth_q) < VERTICES)
    else $error("search depth exceeds the vertex count");

  // A row is pending only while the search is running.
  a_pend_expand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == bfsncd_pkg::S_EXPAND)
    else $error("adjacency row pending outside the search");

endmodule
